// ===== sv/bwr_pkg.sv =====
// Shared types, constants and saturation helpers for the waveguide reflector.
`default_nettype none

package bwr_pkg;

    // Sample format: signed Q1.15
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = SAMPLE_W - 1;
    localparam int MAX_LENGTH = 1024;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int LEN_W      = ADDR_W + 1;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_LINE_LENGTH   = 2'd0;
    localparam logic [1:0] REG_REFLECT_LEFT  = 2'd1;
    localparam logic [1:0] REG_REFLECT_RIGHT = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [LEN_W-1:0]           len_t;

    // Write port of one delay line
    typedef struct packed {
        logic    en;
        addr_t   addr;
        sample_t data;
    } bwr_wr_t;

    // Clamp a signed value of up to SAMPLE_W+2 bits to the sample range
    function automatic sample_t sat_sample(input logic signed [SAMPLE_W+1:0] x);
        logic signed [SAMPLE_W+1:0] hi;
        logic signed [SAMPLE_W+1:0] lo;
        sample_t                    r;
        hi = (SAMPLE_W+2)'($signed({1'b0, {(SAMPLE_W-1){1'b1}}}));
        lo = -hi - (SAMPLE_W+2)'(1);
        if (x > hi)
        begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (x < lo)
        begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            r = x[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bidirectional_waveguide_reflector.sv =====
// Bidirectional waveguide reflector: two delay lines with scattering at both ends.
//
// Input channel (in_valid / in_stall) takes one in_left / in_right pair per item;
// output channel (out_valid / out_stall) gives one out_left / out_right pair per item.
// Throughput: one item per cycle while in_stall is low. The lines are read into the
// read stage when an item is accepted, and the scattering result is loaded into the
// output register, raising out_valid, when the read stage advances. The rate is
// set by the single write and single read per cycle on
// each line memory; an item one line length behind is forwarded when a line of
// length one reads the entry being written in the same cycle.
// Reset: control state clears, registers take line_length 1024 and both
// factors 0, and a clearing pass zeroes both lines; in_stall is
// high during that pass. Configuration writes are taken at any time.
// When out_stall holds the output register, one more item can sit in the read
// stage; after that in_stall rises until the receiver takes the result.
// Writing line_length resets both line pointers and keeps line contents.
// APB: line_length at 0x0, reflect_left at 0x4, reflect_right at 0x8.
`default_nettype none

module bidirectional_waveguide_reflector (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input items
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [bwr_pkg::SAMPLE_W-1:0]  in_left,
    input  wire logic signed [bwr_pkg::SAMPLE_W-1:0]  in_right,
    // result items
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [bwr_pkg::SAMPLE_W-1:0]       out_left,
    output logic signed [bwr_pkg::SAMPLE_W-1:0]       out_right,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bwr_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [bwr_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [bwr_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                      pready
);

    localparam int SW = bwr_pkg::SAMPLE_W;
    localparam int LW = bwr_pkg::LEN_W;
    localparam int DW = bwr_pkg::APB_DATA_W;

    // Configuration registers
    bwr_pkg::len_t    len_reg;
    bwr_pkg::sample_t refl_left_reg;
    bwr_pkg::sample_t refl_right_reg;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;
    bwr_pkg::len_t    len_wdata;

    // Clearing pass
    logic             clear_reg;
    bwr_pkg::addr_t   clear_cnt_reg;

    // Pointers
    bwr_pkg::addr_t   up_ptr_reg;
    bwr_pkg::addr_t   lp_ptr_reg;
    bwr_pkg::addr_t   up_eff;
    bwr_pkg::addr_t   lp_eff;
    bwr_pkg::addr_t   up_ptr_next;
    bwr_pkg::addr_t   lp_ptr_next;
    bwr_pkg::len_t    lp_inc;

    // Read stage
    logic             s0_valid_reg;
    bwr_pkg::addr_t   s0_up_addr_reg;
    bwr_pkg::addr_t   s0_lp_addr_reg;
    bwr_pkg::sample_t s0_in_left_reg;
    bwr_pkg::sample_t s0_in_right_reg;
    logic             fwd_up_reg;
    logic             fwd_lp_reg;
    bwr_pkg::sample_t fwd_up_data_reg;
    bwr_pkg::sample_t fwd_lp_data_reg;

    // Output register
    logic             out_valid_reg;
    bwr_pkg::sample_t out_left_reg;
    bwr_pkg::sample_t out_right_reg;

    // Datapath
    logic             acc;
    logic             s0_adv;
    bwr_pkg::sample_t up_rdata;
    bwr_pkg::sample_t lp_rdata;
    bwr_pkg::sample_t upper_old;
    bwr_pkg::sample_t lower_old;
    bwr_pkg::sample_t upper_wdata;
    bwr_pkg::sample_t lower_wdata;
    bwr_pkg::sample_t trans_left;
    bwr_pkg::sample_t trans_right;
    bwr_pkg::bwr_wr_t up_wr;
    bwr_pkg::bwr_wr_t lp_wr;

    // Handshakes
    assign acc      = in_valid & ~in_stall;
    assign s0_adv   = s0_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = clear_reg | (s0_valid_reg & out_valid_reg & out_stall);

    // APB decode
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_comb
    begin
        len_wdata = pwdata[LW-1:0];
        if (len_wdata == '0)
        begin
            len_wdata = bwr_pkg::LEN_MIN;
        end
        else if (len_wdata > bwr_pkg::LEN_MAX)
        begin
            len_wdata = bwr_pkg::LEN_MAX;
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            bwr_pkg::REG_LINE_LENGTH:   prdata = DW'(len_reg);
            bwr_pkg::REG_REFLECT_LEFT:  prdata = DW'(refl_left_reg);
            bwr_pkg::REG_REFLECT_RIGHT: prdata = DW'(refl_right_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= bwr_pkg::LEN_MAX;
            refl_left_reg  <= '0;
            refl_right_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                bwr_pkg::REG_LINE_LENGTH:   len_reg        <= len_wdata;
                bwr_pkg::REG_REFLECT_LEFT:  refl_left_reg  <= pwdata[SW-1:0];
                bwr_pkg::REG_REFLECT_RIGHT: refl_right_reg <= pwdata[SW-1:0];
                default:                    ;
            endcase
        end
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == '1)
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // Pointer motion: upper counts down, lower counts up
    always_comb
    begin
        up_eff = ({1'b0, up_ptr_reg} >= len_reg) ? '0 : up_ptr_reg;
        lp_eff = ({1'b0, lp_ptr_reg} >= len_reg) ? '0 : lp_ptr_reg;
        lp_inc = {1'b0, lp_eff} + 1'b1;
        up_ptr_next = (up_eff == '0) ? bwr_pkg::ADDR_W'(len_reg - 1'b1) : up_eff - 1'b1;
        lp_ptr_next = (lp_inc >= len_reg) ? '0 : lp_inc[bwr_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_ptr_reg <= '0;
            lp_ptr_reg <= '0;
        end
        else if (cfg_wr && cfg_idx == bwr_pkg::REG_LINE_LENGTH)
        begin
            up_ptr_reg <= '0;
            lp_ptr_reg <= '0;
        end
        else if (acc)
        begin
            up_ptr_reg <= up_ptr_next;
            lp_ptr_reg <= lp_ptr_next;
        end
    end

    // Line write ports: clearing pass, else the item leaving the read stage
    always_comb
    begin
        if (clear_reg)
        begin
            up_wr = '{en: 1'b1, addr: clear_cnt_reg, data: '0};
            lp_wr = '{en: 1'b1, addr: clear_cnt_reg, data: '0};
        end
        else
        begin
            up_wr = '{en: s0_adv, addr: s0_up_addr_reg, data: upper_wdata};
            lp_wr = '{en: s0_adv, addr: s0_lp_addr_reg, data: lower_wdata};
        end
    end

    bwr_line u_upper (
        .clk     (clk),
        .wr      (up_wr),
        .rd_en   (acc),
        .rd_addr (up_eff),
        .rd_data (up_rdata)
    );

    bwr_line u_lower (
        .clk     (clk),
        .wr      (lp_wr),
        .rd_en   (acc),
        .rd_addr (lp_eff),
        .rd_data (lp_rdata)
    );

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (s0_adv)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    // Read stage payload and same-cycle write forwarding
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s0_up_addr_reg  <= up_eff;
            s0_lp_addr_reg  <= lp_eff;
            s0_in_left_reg  <= in_left;
            s0_in_right_reg <= in_right;
            fwd_up_reg      <= s0_adv && (s0_up_addr_reg == up_eff);
            fwd_lp_reg      <= s0_adv && (s0_lp_addr_reg == lp_eff);
            fwd_up_data_reg <= upper_wdata;
            fwd_lp_data_reg <= lower_wdata;
        end
    end

    assign upper_old = fwd_up_reg ? fwd_up_data_reg : up_rdata;
    assign lower_old = fwd_lp_reg ? fwd_lp_data_reg : lp_rdata;

    // Left end: lower line arrives, reflection enters the upper line
    bwr_end u_left (
        .old_sample  (lower_old),
        .inject      (s0_in_left_reg),
        .factor      (refl_left_reg),
        .reflected   (upper_wdata),
        .transmitted (trans_left)
    );

    // Right end: upper line arrives, reflection enters the lower line
    bwr_end u_right (
        .old_sample  (upper_old),
        .inject      (s0_in_right_reg),
        .factor      (refl_right_reg),
        .reflected   (lower_wdata),
        .transmitted (trans_right)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s0_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv)
        begin
            out_left_reg  <= trans_left;
            out_right_reg <= trans_right;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

endmodule

`default_nettype wire

// ===== sv/bwr_line.sv =====
// One delay line: single write port, one read port with registered read data.
`default_nettype none

module bwr_line (
    input  wire logic              clk,
    input  wire bwr_pkg::bwr_wr_t  wr,
    input  wire logic              rd_en,
    input  wire bwr_pkg::addr_t    rd_addr,
    output bwr_pkg::sample_t       rd_data
);

    bwr_pkg::sample_t mem [0:bwr_pkg::MAX_LENGTH-1];
    bwr_pkg::sample_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port; old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/bwr_end.sv =====
// Scattering at one end: reflected part joins the injected sample, rest leaves.
`default_nettype none

module bwr_end (
    input  wire bwr_pkg::sample_t  old_sample,
    input  wire bwr_pkg::sample_t  inject,
    input  wire bwr_pkg::sample_t  factor,
    output bwr_pkg::sample_t       reflected,
    output bwr_pkg::sample_t       transmitted
);

    localparam int SW = bwr_pkg::SAMPLE_W;
    localparam int FW = bwr_pkg::FRAC_W;

    logic signed [2*SW-1:0] prod_refl;
    logic signed [2*SW-1:0] prod_trans;
    logic signed [SW:0]     refl_q;
    logic signed [SW:0]     trans_q;
    logic signed [SW+1:0]   one_minus_r;
    logic signed [SW+1:0]   sum;
    bwr_pkg::sample_t       trans_factor;

    // 1 - r, saturated
    assign one_minus_r  = $signed({3'b001, {FW{1'b0}}}) - (SW+2)'(factor);
    assign trans_factor = bwr_pkg::sat_sample(one_minus_r);

    // Products truncated toward minus infinity; top bit kept for sign and +1.0
    assign prod_refl  = old_sample * factor;
    assign prod_trans = old_sample * trans_factor;
    assign refl_q     = prod_refl[2*SW-1:FW];
    assign trans_q    = prod_trans[2*SW-1:FW];

    // Reflected part plus injection, saturated
    assign sum         = (SW+2)'(inject) + (SW+2)'(refl_q);
    assign reflected   = bwr_pkg::sat_sample(sum);
    assign transmitted = bwr_pkg::sat_sample((SW+2)'(trans_q));

endmodule

`default_nettype wire

// ===== test/bidirectional_waveguide_reflector_tb.sv =====
// Self-checking testbench for the bidirectional waveguide reflector.
`timescale 1ns / 1ps

module bidirectional_waveguide_reflector_tb;

    // Register index that decodes to nothing
    localparam logic [1:0] REG_SPARE = 2'd3;
    // Q1.15 representation of 1.0 (one past the largest sample)
    localparam longint Q_ONE = longint'(1) << bwr_pkg::FRAC_W;
    localparam longint SAMPLE_HI = Q_ONE - 1;
    localparam longint SAMPLE_LO = -Q_ONE;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        bwr_pkg::sample_t out_left;
        bwr_pkg::sample_t out_right;
    } wave_out_t;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Block inputs, all known from time zero
    logic                           in_valid = 1'b0;
    bwr_pkg::sample_t               in_left = '0;
    bwr_pkg::sample_t               in_right = '0;
    logic                           out_stall = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [bwr_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [bwr_pkg::APB_DATA_W-1:0] pwdata = '0;

    // Block outputs
    logic                           in_stall;
    logic                           out_valid;
    bwr_pkg::sample_t               out_left;
    bwr_pkg::sample_t               out_right;
    logic [bwr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Predicted waveguide state
    bwr_pkg::sample_t upper_mem [bwr_pkg::MAX_LENGTH];
    bwr_pkg::sample_t lower_mem [bwr_pkg::MAX_LENGTH];
    int unsigned      upper_ptr = 0;
    int unsigned      lower_ptr = 0;
    int unsigned      line_len = bwr_pkg::MAX_LENGTH;
    bwr_pkg::sample_t gain_left = '0;
    bwr_pkg::sample_t gain_right = '0;

    wave_out_t   expected_outputs [$];
    wave_out_t   oldest_output;

    // Run bookkeeping
    int  fail_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  writes_seen = 0;
    bit  gaps_on = 1'b1;
    bit  stall_random = 1'b1;
    int  hold_request = 0;
    int  hold_count = 0;
    int  idle_cycles = 0;

    bidirectional_waveguide_reflector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_left   (in_left),
        .in_right  (in_right),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_left  (out_left),
        .out_right (out_right),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        foreach (upper_mem[i])
        begin
            upper_mem[i] = '0;
            lower_mem[i] = '0;
        end
    end

    // Saturating clamp to the sample range
    function automatic bwr_pkg::sample_t clamp_sample(input longint x);
        if (x > SAMPLE_HI)
        begin
            return bwr_pkg::sample_t'(SAMPLE_HI);
        end
        if (x < SAMPLE_LO)
        begin
            return bwr_pkg::sample_t'(SAMPLE_LO);
        end
        return bwr_pkg::sample_t'(x);
    endfunction

    // Exact product, low fraction bits dropped (floor)
    function automatic longint q15_product(input longint a, input longint b);
        return (a * b) >>> bwr_pkg::FRAC_W;
    endfunction

    // Register write as the block should see it
    task automatic apply_register(input logic [1:0] idx,
                                  input logic [bwr_pkg::APB_DATA_W-1:0] value);
        int unsigned len;
        case (idx)
            bwr_pkg::REG_LINE_LENGTH:
            begin
                len = 32'(value[bwr_pkg::LEN_W-1:0]);
                if (len == 0)
                begin
                    len = 1;
                end
                if (len > bwr_pkg::MAX_LENGTH)
                begin
                    len = bwr_pkg::MAX_LENGTH;
                end
                line_len = len;
                upper_ptr = 0;
                lower_ptr = 0;
            end
            bwr_pkg::REG_REFLECT_LEFT:  gain_left = value[bwr_pkg::SAMPLE_W-1:0];
            bwr_pkg::REG_REFLECT_RIGHT: gain_right = value[bwr_pkg::SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    // One scattering step at both ends; queues the transmitted pair
    task automatic scatter_sample(input bwr_pkg::sample_t left_in,
                                  input bwr_pkg::sample_t right_in);
        int unsigned      up;
        int unsigned      lp;
        bwr_pkg::sample_t lower_old;
        bwr_pkg::sample_t upper_old;
        longint           pass_l;
        longint           pass_r;
        wave_out_t        res;
        up = (upper_ptr >= line_len) ? 0 : upper_ptr;
        lp = (lower_ptr >= line_len) ? 0 : lower_ptr;
        lower_old = lower_mem[lp];
        upper_old = upper_mem[up];
        // 1 - r saturates when r is zero or negative
        pass_l = clamp_sample(Q_ONE - longint'(gain_left));
        pass_r = clamp_sample(Q_ONE - longint'(gain_right));
        res.out_left = clamp_sample(q15_product(lower_old, pass_l));
        res.out_right = clamp_sample(q15_product(upper_old, pass_r));
        upper_mem[up] = clamp_sample(longint'(left_in) + q15_product(lower_old, gain_left));
        lower_mem[lp] = clamp_sample(longint'(right_in) + q15_product(upper_old, gain_right));
        upper_ptr = (up == 0) ? line_len - 1 : up - 1;
        lower_ptr = (lp + 1 >= line_len) ? 0 : lp + 1;
        expected_outputs.push_back(res);
    endtask

    // Input monitor: register writes and accepted items feed the predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                apply_register(paddr[3:2], pwdata);
                writes_seen++;
            end
            if (in_valid && !in_stall)
            begin
                scatter_sample(in_left, in_right);
                items_sent++;
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("result item with nothing expected: out_left %0d out_right %0d",
                       out_left, out_right);
                fail_count++;
            end
            else
            begin
                oldest_output = expected_outputs.pop_front();
                results_checked++;
                if (out_left !== oldest_output.out_left)
                begin
                    $error("out_left: expected %0d, got %0d", oldest_output.out_left, out_left);
                    fail_count++;
                end
                if (out_right !== oldest_output.out_right)
                begin
                    $error("out_right: expected %0d, got %0d", oldest_output.out_right,
                           out_right);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long counted hold when asked
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_count = hold_request;
            hold_request = 0;
        end
        if (hold_count != 0)
        begin
            out_stall <= 1'b1;
            hold_count--;
        end
        else if (stall_random)
        begin
            out_stall <= ($urandom_range(99) < 25);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no traffic at all
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (psel && penable && pwrite))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // APB write: setup phase, then access phase, then idle
    task automatic write_register(input logic [1:0] idx,
                                  input logic [bwr_pkg::APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item and wait until it is accepted
    task automatic send_item(input bwr_pkg::sample_t left_in, input bwr_pkg::sample_t right_in);
        while (gaps_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_left <= left_in;
        in_right <= right_in;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Stop offering and wait for every expected result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_outputs.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic bwr_pkg::sample_t random_sample();
        case ($urandom_range(9))
            0: return bwr_pkg::sample_t'(SAMPLE_HI);
            1: return bwr_pkg::sample_t'(SAMPLE_LO);
            2: return '0;
            default: return bwr_pkg::sample_t'($urandom);
        endcase
    endfunction

    // Factor word with random upper bits; extremes often
    function automatic logic [bwr_pkg::APB_DATA_W-1:0] random_factor_word();
        logic [bwr_pkg::APB_DATA_W-1:0] w;
        w = $urandom;
        case ($urandom_range(4))
            0: w[bwr_pkg::SAMPLE_W-1:0] = 16'h8000;
            1: w[bwr_pkg::SAMPLE_W-1:0] = 16'h7fff;
            2: w[bwr_pkg::SAMPLE_W-1:0] = 16'h0000;
            default: ;
        endcase
        return w;
    endfunction

    // Lines must read back as zero after the clearing pass
    task automatic test_reset_state();
        repeat (2) @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        repeat (4) send_item(random_sample(), random_sample());
        drain_results();
    endtask

    // Extremes of fields and registers, and the odd register values
    task automatic test_directed_extremes();
        // length one: every item feeds straight back
        write_register(bwr_pkg::REG_LINE_LENGTH, 32'd1);
        write_register(bwr_pkg::REG_REFLECT_LEFT, 32'h0000_8000);
        write_register(bwr_pkg::REG_REFLECT_RIGHT, 32'h0000_7fff);
        send_item(16'sh7fff, 16'sh8000);
        send_item(16'sh7fff, 16'sh8000);
        send_item(16'sh8000, 16'sh7fff);
        send_item(16'sh8000, 16'sh7fff);
        send_item(16'sh0000, 16'sh0000);
        send_item(16'shffff, 16'sh0001);
        drain_results();
        // zero length acts as one; both factors at minus one
        write_register(bwr_pkg::REG_LINE_LENGTH, 32'd0);
        write_register(bwr_pkg::REG_REFLECT_LEFT, 32'h0000_8000);
        write_register(bwr_pkg::REG_REFLECT_RIGHT, 32'hffff_8000);
        send_item(16'sh7fff, 16'sh7fff);
        send_item(16'sh8000, 16'sh8000);
        send_item(16'sh3039, -16'sh3039);
        send_item(16'sh0001, 16'shffff);
        drain_results();
        // write to a register that does not exist, then an oversized length
        write_register(REG_SPARE, 32'h0000_7fff);
        write_register(bwr_pkg::REG_LINE_LENGTH, 32'h0000_07ff);
        send_item(16'sh7fff, 16'sh8000);
        send_item(16'sh7fff, 16'sh8000);
        drain_results();
        // short line, full positive reflection on the left only
        write_register(bwr_pkg::REG_LINE_LENGTH, 32'd2);
        write_register(bwr_pkg::REG_REFLECT_LEFT, 32'h0000_7fff);
        write_register(bwr_pkg::REG_REFLECT_RIGHT, 32'h0000_0000);
        repeat (4) send_item(random_sample(), random_sample());
        drain_results();
    endtask

    // Receiver holds off long enough that the input side stalls
    task automatic test_backpressure();
        write_register(bwr_pkg::REG_LINE_LENGTH, 32'd3);
        write_register(bwr_pkg::REG_REFLECT_LEFT, random_factor_word());
        write_register(bwr_pkg::REG_REFLECT_RIGHT, random_factor_word());
        gaps_on = 1'b0;
        stall_random = 1'b0;
        hold_request = 60;
        repeat (30) send_item(random_sample(), random_sample());
        drain_results();
        gaps_on = 1'b1;
        stall_random = 1'b1;
    endtask

    // One random register setting followed by a burst of items
    task automatic run_random_phase(input int n_items, input bit quiet);
        logic [bwr_pkg::APB_DATA_W-1:0] len_word;
        int                             pick;
        gaps_on = !quiet;
        stall_random = !quiet;
        len_word = $urandom;
        pick = $urandom_range(99);
        // mostly short lines so the feedback is exercised
        if (pick < 65)
        begin
            len_word[bwr_pkg::LEN_W-1:0] = bwr_pkg::LEN_W'($urandom_range(1, 12));
        end
        else if (pick < 80)
        begin
            len_word[bwr_pkg::LEN_W-1:0] = bwr_pkg::LEN_W'($urandom_range(13, 64));
        end
        else if (pick < 87)
        begin
            len_word[bwr_pkg::LEN_W-1:0] = '0;
        end
        else if (pick < 94)
        begin
            len_word[bwr_pkg::LEN_W-1:0] =
                bwr_pkg::LEN_W'($urandom_range(bwr_pkg::MAX_LENGTH + 1, 2047));
        end
        else
        begin
            len_word[bwr_pkg::LEN_W-1:0] =
                bwr_pkg::LEN_W'($urandom_range(65, bwr_pkg::MAX_LENGTH));
        end
        write_register(bwr_pkg::REG_LINE_LENGTH, len_word);
        write_register(bwr_pkg::REG_REFLECT_LEFT, random_factor_word());
        write_register(bwr_pkg::REG_REFLECT_RIGHT, random_factor_word());
        repeat (n_items) send_item(random_sample(), random_sample());
        drain_results();
        gaps_on = 1'b1;
        stall_random = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 9; p++)
        begin
            run_random_phase(45, p == 3);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed_extremes();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        if (expected_outputs.size() != 0)
        begin
            $error("%0d expected result items never arrived", expected_outputs.size());
            fail_count++;
        end
        $display("Covered %0d items and %0d checked results over %0d register writes,",
                 items_sent, results_checked, writes_seen);
        $display("with line lengths from one to the maximum and factors at both limits.");
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
